/* rtl/core/upc_pkg.sv */
package upc_pkg;

    // Input item: one message byte and its end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    // Result item: one converted byte and its end marker
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Bytes caused by one input item, oldest in slot 0
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
    } bundle_t;

    // Configuration register indexes
    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_PLUS      = 1'b1;

    // Decoder hold states
    localparam logic [1:0] HOLD_NONE    = 2'd0;
    localparam logic [1:0] HOLD_PERCENT = 2'd1;
    localparam logic [1:0] HOLD_DIGIT   = 2'd2;

    // Characters
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_USCORE  = 8'h5F;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    // Offsets that map 'A'..'F' and 'a'..'f' onto 10..15
    localparam logic [7:0] UPPER_HEX_OFS = 8'h37;
    localparam logic [7:0] LOWER_HEX_OFS = 8'h57;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c)
            || ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F))
            || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (is_digit(c))
        begin
            t = c - CHAR_ZERO;
        end
        else if (c <= CHAR_UPPER_F)
        begin
            t = c - UPPER_HEX_OFS;
        end
        else
        begin
            t = c - LOWER_HEX_OFS;
        end
        return t[3:0];
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return is_digit(c)
            || ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
            || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z))
            || (c == CHAR_DASH) || (c == CHAR_USCORE)
            || (c == CHAR_DOT) || (c == CHAR_TILDE);
    endfunction

    // Upper-case hex digit for a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return CHAR_ZERO + {4'h0, n};
        end
        return UPPER_HEX_OFS + {4'h0, n};
    endfunction

endpackage

/* rtl/core/url_percent_codec.sv */
// Path: an accepted item's bytes are written to the bundle queue, then loaded into the
// back stage's current-bundle register, which drives the result port.
// Throughput: one result byte per cycle while pop is held; an encoded byte gives up to
// three result bytes, so the single result port sets the sustained rate. Input is taken
// every cycle while the bundle queue has room.
// Reset (rst_n, async, active low) clears both registers, held decode state, the
// queue and the output stage; full is low out of reset, so input is taken after release.
module url_percent_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic               cfg_data,
    input  logic               push,
    output logic               full,
    input  upc_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output upc_pkg::out_item_t out_item
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    upc_pkg::bundle_t q_wr_data;
    upc_pkg::bundle_t q_rd_data;

    // Front: classify bytes, hold decode state
    upc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .q_push    (q_push),
        .q_data    (q_wr_data),
        .q_full    (q_full)
    );

    // Bundle queue between front and back
    upc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    // Back: serialize bundles onto the result port
    upc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_rd_data),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

/* rtl/core/upc_front.sv */
module upc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic              cfg_data,
    input  logic              push,
    output logic              full,
    input  upc_pkg::in_item_t in_item,
    output logic              q_push,
    output upc_pkg::bundle_t  q_data,
    input  logic              q_full
);

    logic       direction_reg;
    logic       plus_reg;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       accept;

    upc_pkg::bundle_t bundle;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Classify the byte and build the bytes it causes
    always_comb
    begin
        logic [7:0] b;
        logic [1:0] n;
        logic       pend_pct;
        b        = in_item.data_byte;
        n        = 2'd0;
        pend_pct = 1'b0;
        bundle   = '0;
        pending_next = upc_pkg::HOLD_NONE;
        held_next    = held_reg;
        if (!direction_reg)
        begin
            // encode
            if (upc_pkg::is_unreserved(b))
            begin
                bundle.bytes[0] = b;
                n = 2'd1;
            end
            else if ((b == upc_pkg::CHAR_SPACE) && plus_reg)
            begin
                bundle.bytes[0] = upc_pkg::CHAR_PLUS;
                n = 2'd1;
            end
            else
            begin
                bundle.bytes[0] = upc_pkg::CHAR_PERCENT;
                bundle.bytes[1] = upc_pkg::hex_digit(b[7:4]);
                bundle.bytes[2] = upc_pkg::hex_digit(b[3:0]);
                n = 2'd3;
            end
        end
        else
        begin
            // decode: first settle what was held
            logic fresh;
            fresh = 1'b0;
            unique case (pending_reg)
                upc_pkg::HOLD_PERCENT:
                begin
                    if (upc_pkg::is_hex(b))
                    begin
                        pending_next = upc_pkg::HOLD_DIGIT;
                        held_next    = b;
                    end
                    else
                    begin
                        bundle.bytes[0] = upc_pkg::CHAR_PERCENT;
                        n = 2'd1;
                        fresh = 1'b1;
                    end
                end
                upc_pkg::HOLD_DIGIT:
                begin
                    if (upc_pkg::is_hex(b))
                    begin
                        bundle.bytes[0] = {upc_pkg::hex_val(held_reg), upc_pkg::hex_val(b)};
                        n = 2'd1;
                    end
                    else
                    begin
                        bundle.bytes[0] = upc_pkg::CHAR_PERCENT;
                        bundle.bytes[1] = held_reg;
                        n = 2'd2;
                        fresh = 1'b1;
                    end
                end
                default:
                begin
                    fresh = 1'b1;
                end
            endcase
            // breaking byte, or byte with nothing held
            if (fresh)
            begin
                if (b == upc_pkg::CHAR_PERCENT)
                begin
                    pending_next = upc_pkg::HOLD_PERCENT;
                    pend_pct = 1'b1;
                end
                else
                begin
                    bundle.bytes[n] = ((b == upc_pkg::CHAR_PLUS) && plus_reg)
                                    ? upc_pkg::CHAR_SPACE : b;
                    n = n + 2'd1;
                end
            end
            // flush held bytes at end of message
            if (in_item.end_of_message)
            begin
                if (pending_next != upc_pkg::HOLD_NONE)
                begin
                    bundle.bytes[n] = upc_pkg::CHAR_PERCENT;
                    n = n + 2'd1;
                end
                if ((pending_next == upc_pkg::HOLD_DIGIT) && !pend_pct)
                begin
                    bundle.bytes[n] = held_next;
                    n = n + 2'd1;
                end
                pending_next = upc_pkg::HOLD_NONE;
            end
        end
        bundle.count = n;
        bundle.last  = in_item.end_of_message;
    end

    assign q_push = accept && (bundle.count != 2'd0);
    assign q_data = bundle;

    // Configuration and decoder hold state; a direction write drops held bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            plus_reg      <= 1'b0;
            pending_reg   <= upc_pkg::HOLD_NONE;
            held_reg      <= 8'h00;
        end
        else
        begin
            if (cfg_we && (cfg_index == upc_pkg::CFG_DIRECTION))
            begin
                pending_reg <= upc_pkg::HOLD_NONE;
            end
            else if (accept)
            begin
                pending_reg <= pending_next;
            end
            if (accept)
            begin
                held_reg <= held_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    upc_pkg::CFG_DIRECTION:
                    begin
                        direction_reg <= cfg_data;
                    end
                    upc_pkg::CFG_PLUS:
                    begin
                        plus_reg <= cfg_data;
                    end
                endcase
            end
        end
    end

`ifndef SYNTH
    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("hold state out of range");
    a_encode_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !direction_reg |-> (pending_reg == upc_pkg::HOLD_NONE))
        else $error("bytes held in encode mode");
    a_dir_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == upc_pkg::CFG_DIRECTION))
        |=> (pending_reg == upc_pkg::HOLD_NONE))
        else $error("direction write left bytes held");
    a_eom_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.end_of_message) |-> q_push)
        else $error("end of message produced no bytes");
`endif

endmodule

/* rtl/core/upc_queue.sv */
module upc_queue #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  upc_pkg::bundle_t wr_data,
    output logic             q_full,
    input  logic             rd_en,
    output upc_pkg::bundle_t rd_data,
    output logic             q_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    upc_pkg::bundle_t mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == DEPTH_CNT);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count overflow");
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && q_full))
        else $error("write into full queue");
    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && q_empty))
        else $error("read from empty queue");
`endif

endmodule

/* rtl/core/upc_back.sv */
module upc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  upc_pkg::bundle_t   q_data,
    input  logic               q_empty,
    output logic               q_pop,
    output upc_pkg::out_item_t out_item,
    output logic               empty,
    input  logic               pop
);

    upc_pkg::bundle_t cur_reg;
    logic             cur_valid_reg;
    logic [1:0]       idx_reg;
    logic             final_byte;
    logic             take;
    logic             load;

    assign final_byte = (idx_reg == (cur_reg.count - 2'd1));
    assign take       = pop && cur_valid_reg;
    assign load       = !cur_valid_reg || (take && final_byte);
    assign q_pop      = load && !q_empty;

    // Result ports come straight from the current bundle
    assign empty             = !cur_valid_reg;
    assign out_item.out_byte = cur_reg.bytes[idx_reg];
    assign out_item.out_last = cur_reg.last && final_byte;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    // Step through the bundle one byte per pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            cur_valid_reg <= !q_empty;
            idx_reg       <= 2'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

`ifndef SYNTH
    a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.count != 2'd0))
        else $error("empty bundle loaded");
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg < cur_reg.count))
        else $error("byte index past bundle");
    a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !cur_valid_reg |-> (idx_reg == 2'd0))
        else $error("index not reset while idle");
`endif

endmodule

/* sim/url_percent_codec_test.sv */
`timescale 1ns / 1ps

module url_percent_codec_test;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic               cfg_data;
    logic               push;
    logic               full;
    upc_pkg::in_item_t  in_item;
    logic               empty;
    logic               pop = 1'b0;
    upc_pkg::out_item_t out_item;

    url_percent_codec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the codec registers and decode hold state
    logic       mode_decode = 1'b0;
    logic       mode_plus   = 1'b0;
    logic [1:0] hold_state  = upc_pkg::HOLD_NONE;
    logic [7:0] held_digit  = 8'h00;

    // Bytes produced by the item being predicted, and the expected result stream
    logic [7:0]         produced[$];
    upc_pkg::out_item_t expected_bytes[$];
    upc_pkg::out_item_t want_item;

    int idle_pct     = 36;
    int items_sent   = 0;
    int messages     = 0;
    int results_seen = 0;
    int reg_writes   = 0;
    int fail_count   = 0;

    function automatic bit is_decimal(input logic [7:0] c);
        return (c >= upc_pkg::CHAR_ZERO) && (c <= upc_pkg::CHAR_NINE);
    endfunction

    function automatic bit is_hex_char(input logic [7:0] c);
        return is_decimal(c)
            || ((c >= upc_pkg::CHAR_UPPER_A) && (c <= upc_pkg::CHAR_UPPER_F))
            || ((c >= upc_pkg::CHAR_LOWER_A) && (c <= upc_pkg::CHAR_LOWER_F));
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (is_decimal(c))
        begin
            v = c - upc_pkg::CHAR_ZERO;
        end
        else if (c <= upc_pkg::CHAR_UPPER_F)
        begin
            v = c - upc_pkg::CHAR_UPPER_A + 8'd10;
        end
        else
        begin
            v = c - upc_pkg::CHAR_LOWER_A + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] upper_hex(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return upc_pkg::CHAR_ZERO + 8'(n);
        end
        return upc_pkg::CHAR_UPPER_A + 8'(n) - 8'd10;
    endfunction

    function automatic bit passes_through(input logic [7:0] c);
        return is_decimal(c)
            || ((c >= upc_pkg::CHAR_UPPER_A) && (c <= upc_pkg::CHAR_UPPER_Z))
            || ((c >= upc_pkg::CHAR_LOWER_A) && (c <= upc_pkg::CHAR_LOWER_Z))
            || (c == upc_pkg::CHAR_DASH) || (c == upc_pkg::CHAR_USCORE)
            || (c == upc_pkg::CHAR_DOT) || (c == upc_pkg::CHAR_TILDE);
    endfunction

    // Append one byte to the prediction of the current item
    task automatic emit_byte(input logic [7:0] b);
        produced = {produced, b};
    endtask

    // Decode a byte with nothing held
    task automatic decode_fresh(input logic [7:0] b);
        if (b == upc_pkg::CHAR_PERCENT)
        begin
            hold_state = upc_pkg::HOLD_PERCENT;
        end
        else if ((b == upc_pkg::CHAR_PLUS) && mode_plus)
        begin
            emit_byte(upc_pkg::CHAR_SPACE);
        end
        else
        begin
            emit_byte(b);
        end
    endtask

    // Work out the result bytes that one accepted item causes
    task automatic convert_byte(input logic [7:0] b, input logic eom);
        upc_pkg::out_item_t r;
        produced.delete();
        if (mode_decode)
        begin
            case (hold_state)
                upc_pkg::HOLD_PERCENT:
                begin
                    if (is_hex_char(b))
                    begin
                        held_digit = b;
                        hold_state = upc_pkg::HOLD_DIGIT;
                    end
                    else
                    begin
                        hold_state = upc_pkg::HOLD_NONE;
                        emit_byte(upc_pkg::CHAR_PERCENT);
                        decode_fresh(b);
                    end
                end
                upc_pkg::HOLD_DIGIT:
                begin
                    hold_state = upc_pkg::HOLD_NONE;
                    if (is_hex_char(b))
                    begin
                        emit_byte({nibble_of(held_digit), nibble_of(b)});
                    end
                    else
                    begin
                        emit_byte(upc_pkg::CHAR_PERCENT);
                        emit_byte(held_digit);
                        decode_fresh(b);
                    end
                end
                default:
                begin
                    hold_state = upc_pkg::HOLD_NONE;
                    decode_fresh(b);
                end
            endcase
            // flush anything still held at message end
            if (eom)
            begin
                if (hold_state != upc_pkg::HOLD_NONE)
                begin
                    emit_byte(upc_pkg::CHAR_PERCENT);
                end
                if (hold_state == upc_pkg::HOLD_DIGIT)
                begin
                    emit_byte(held_digit);
                end
                hold_state = upc_pkg::HOLD_NONE;
            end
        end
        else
        begin
            hold_state = upc_pkg::HOLD_NONE;
            if (passes_through(b))
            begin
                emit_byte(b);
            end
            else if ((b == upc_pkg::CHAR_SPACE) && mode_plus)
            begin
                emit_byte(upc_pkg::CHAR_PLUS);
            end
            else
            begin
                emit_byte(upc_pkg::CHAR_PERCENT);
                emit_byte(upper_hex(b[7:4]));
                emit_byte(upper_hex(b[3:0]));
            end
        end
        foreach (produced[i])
        begin
            r.out_byte = produced[i];
            r.out_last = eom && (i == produced.size() - 1);
            expected_bytes = {expected_bytes, r};
        end
        if (eom)
        begin
            messages++;
        end
    endtask

    // Send one item, idling at random first; push stays high after acceptance
    task automatic send_item(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= '{data_byte: b, end_of_message: eom};
        do
        begin
            @(posedge clk);
        end
        while (full);
        convert_byte(b, eom);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit eom);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(s[i], eom && (i == s.len() - 1));
        end
    endtask

    // Stop sending and wait until every expected byte has come out
    task automatic drain();
        push <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        // an item that gives no byte may still be in flight
        repeat (4) @(posedge clk);
    endtask

    // Write both registers once the block is idle; a direction write drops held bytes
    task automatic configure(input logic dir, input logic plus);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= upc_pkg::CFG_DIRECTION;
        cfg_data  <= dir;
        @(posedge clk);
        mode_decode = dir;
        hold_state  = upc_pkg::HOLD_NONE;
        cfg_index <= upc_pkg::CFG_PLUS;
        cfg_data  <= plus;
        @(posedge clk);
        mode_plus = plus;
        cfg_we <= 1'b0;
        reg_writes += 2;
    endtask

    function automatic logic [7:0] random_hex_char();
        logic [3:0] n;
        n = 4'($urandom_range(15));
        if (n < 4'd10)
        begin
            return upc_pkg::CHAR_ZERO + 8'(n);
        end
        if ($urandom_range(1))
        begin
            return upc_pkg::CHAR_LOWER_A + 8'(n) - 8'd10;
        end
        return upc_pkg::CHAR_UPPER_A + 8'(n) - 8'd10;
    endfunction

    // Encoder corners: zero, all ones, pass-through marks, space both ways
    task automatic test_encode_directed();
        configure(1'b0, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("z_~ %", 1'b1);
        configure(1'b0, 1'b1);
        send_text(" ", 1'b1);
    endtask

    // Decoder corners: broken sequences, restart on '%', flush, plus, discard
    task automatic test_decode_directed();
        configure(1'b1, 1'b1);
        send_text("%A%20", 1'b0);
        send_text("%G", 1'b0);
        send_text("+", 1'b1);
        send_text("%", 1'b1);
        send_text("%F", 1'b1);
        send_text("%4f", 1'b1);
        // held '%' is dropped by the direction write
        send_text("%", 1'b0);
        configure(1'b1, 1'b0);
        send_text("+", 1'b1);
    endtask

    // Random messages under one register setting
    task automatic test_random(input logic dir, input logic plus, input int n_items,
                               input int idle);
        logic [7:0] msg[$];
        int         r;
        int         sent;
        configure(dir, plus);
        idle_pct = idle;
        sent = 0;
        while (sent < n_items)
        begin
            msg.delete();
            repeat ($urandom_range(1, 5))
            begin
                r = $urandom_range(99);
                if (dir && (r < 50))
                begin
                    msg = {msg, upc_pkg::CHAR_PERCENT};
                    msg = {msg, random_hex_char()};
                    msg = {msg, random_hex_char()};
                end
                else if (dir && (r < 62))
                begin
                    msg = {msg, upc_pkg::CHAR_PLUS};
                end
                else if (dir && (r < 74))
                begin
                    // percent, maybe one digit, then a random byte that may break the sequence
                    msg = {msg, upc_pkg::CHAR_PERCENT};
                    if ($urandom_range(1))
                    begin
                        msg = {msg, random_hex_char()};
                    end
                    msg = {msg, 8'($urandom_range(255))};
                end
                else if (!dir && (r < 15))
                begin
                    msg = {msg, upc_pkg::CHAR_SPACE};
                end
                else
                begin
                    msg = {msg, 8'($urandom_range(255))};
                end
            end
            foreach (msg[i])
            begin
                send_item(msg[i], i == msg.size() - 1);
            end
            sent += msg.size();
        end
        // sometimes leave a '%' held across the next direction write
        if (dir && $urandom_range(1))
        begin
            send_item(upc_pkg::CHAR_PERCENT, 1'b0);
        end
        idle_pct = 36;
    endtask

    // Result checker and random stalls on the output side
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (expected_bytes.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual byte %h last %b",
                         $time, out_item.out_byte, out_item.out_last);
            end
            else
            begin
                want_item = expected_bytes.pop_front();
                if (out_item.out_byte !== want_item.out_byte)
                begin
                    fail_count++;
                    $display("%0t: out_byte mismatch, expected %h actual %h",
                             $time, want_item.out_byte, out_item.out_byte);
                end
                if (out_item.out_last !== want_item.out_last)
                begin
                    fail_count++;
                    $display("%0t: out_last mismatch, expected %b actual %b",
                             $time, want_item.out_last, out_item.out_last);
                end
            end
        end
        pop <= rst_n && ($urandom_range(99) >= idle_pct);
    end

    // Main sequence
    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = upc_pkg::CFG_DIRECTION;
        cfg_data  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_directed();
        test_decode_directed();
        test_random(1'b0, 1'b0, 40, 36);
        test_random(1'b1, 1'b1, 50, 36);
        test_random(1'b0, 1'b1, 35, 0);
        test_random(1'b1, 1'b0, 50, 36);
        test_random(1'b1, 1'b1, 45, 0);

        drain();
        repeat (8) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
        end
        $display("Sent %0d items in %0d messages, checked %0d result bytes,",
                 items_sent, messages, results_seen);
        $display("both directions and both plus settings, %0d register writes", reg_writes);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/upc_pkg.sv
rtl/core/upc_front.sv
rtl/core/upc_queue.sv
rtl/core/upc_back.sv
rtl/core/url_percent_codec.sv
sim/url_percent_codec_test.sv
